// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the integer-to-text converter.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ria_pkg.sv =====
// Package for the radix integer-to-ASCII converter: FSM state type,
// controller/datapath command and status words, character constants.
// No dependencies.
package ria_pkg;

  // Base handling
  localparam logic [5:0] DEFAULT_RADIX = 6'd10;
  localparam logic [5:0] MAX_RADIX     = 6'd36;

  // Bits of the dividend consumed per divider cycle
  localparam int CHUNK_BITS = 8;

  // ASCII codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_ALPHA = 7'h41;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_last;  // divider on its final chunk of the current digit
    logic quot_zero;  // quotient after this chunk is zero
    logic neg;        // value being converted is negative
    logic nd_one;     // one digit left on the stack
  } status_t;

  // Digit value 0..35 to its character
  function automatic logic [6:0] digit_code(input logic [5:0] d);
    logic [6:0] code;
    if (d < 6'd10) begin
      code = CH_ZERO + {1'b0, d};
    end else begin
      code = CH_ALPHA + {1'b0, d} - 7'd10;
    end
    return code;
  endfunction

endpackage

// ===== src/radix_integer_to_ascii_top.sv =====
// Top level of the radix integer-to-ASCII converter.
// Joins ria_ctrl and ria_datapath; uses ria_pkg and assert_macros.svh.
//
// Usage:
//   Input: drive value (signed, low VALUE_BITS bits used) and radix, raise
//   start; the word is taken at the rising edge where start is high and busy
//   is low. Radix 0 or 1 means ten; radix above 36 is treated as 36.
//   Output: one character per word on char_code, valid for exactly one cycle
//   while strobe is high; last marks the final character. A negative value
//   gives '-' first. Zero gives a single '0'.
//   Timing: the chunked divider yields 8 quotient bits per cycle and works
//   through the whole dividend for each digit; once every digit is divided,
//   an optional sign and then the digits from the stack are sent, each through
//   the registered output word. busy drops in the cycle the last character
//   is shown, so the next start can be taken there.
//   One item is in work at a time; the digit stack ties each item to the end
//   of the previous one.
//   Reset: synchronous, active high; returns to idle, strobe low.
//   The receiver cannot stall: every strobe cycle is a delivered character.
`include "assert_macros.svh"

module radix_integer_to_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value,
  input  logic [5:0]  radix,
  output logic        strobe,
  output logic [6:0]  char_code,
  output logic        last
);

  ria_pkg::cmd_t    cmd;
  ria_pkg::status_t status;

  // Sequencer
  ria_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Divider, digit stack and output register
  ria_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .radix     (radix),
    .cmd       (cmd),
    .status    (status),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

  // Checks
  `ASSERT_IMPLY(a_strobe_from_busy, strobe, $past(busy), "character word without an item in work")
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `ASSERT_NEXT(a_last_ends, strobe && last, !strobe, "character word after the last one")
  `ASSERT_IMPLY(a_more_busy, strobe && !last, busy, "idle before the last character")

endmodule

// ===== src/ria_ctrl.sv =====
// Controller FSM for the integer-to-text converter.
// Sequences load, digit division, sign and digit emission. Uses ria_pkg.
module ria_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ria_pkg::status_t status,
  output ria_pkg::cmd_t    cmd,
  output logic             busy
);

  ria_pkg::state_t state;
  ria_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ria_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ria_pkg::ST_IDLE: begin
        if (start) state_next = ria_pkg::ST_DIV;
      end
      ria_pkg::ST_DIV: begin
        if (status.step_last && status.quot_zero) begin
          state_next = status.neg ? ria_pkg::ST_SIGN : ria_pkg::ST_DIGIT;
        end
      end
      ria_pkg::ST_SIGN: begin
        state_next = ria_pkg::ST_DIGIT;
      end
      ria_pkg::ST_DIGIT: begin
        if (status.nd_one) state_next = ria_pkg::ST_IDLE;
      end
      default: state_next = ria_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ria_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ria_pkg::ST_DIV:   cmd.div_step   = 1'b1;
      ria_pkg::ST_SIGN:  cmd.emit_sign  = 1'b1;
      ria_pkg::ST_DIGIT: cmd.emit_digit = 1'b1;
      default:           busy           = 1'b0;
    endcase
  end

endmodule

// ===== src/ria_datapath.sv =====
// Datapath for the integer-to-text converter: magnitude/radix registers,
// chunked restoring divider, digit stack and output word register. Uses ria_pkg.
module ria_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      value,
  input  logic [5:0]       radix,
  input  ria_pkg::cmd_t    cmd,
  output ria_pkg::status_t status,
  output logic             strobe,
  output logic [6:0]       char_code,
  output logic             last
);

  localparam int STEPS = (VALUE_BITS + ria_pkg::CHUNK_BITS - 1) / ria_pkg::CHUNK_BITS;
  localparam int DW    = STEPS * ria_pkg::CHUNK_BITS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int NW    = $clog2(VALUE_BITS + 1);
  localparam int IW    = $clog2(VALUE_BITS);

  logic [DW-1:0]         dividend;
  logic [5:0]            rad;
  logic                  neg;
  logic [5:0]            rem;
  logic [SW-1:0]         step;
  logic [NW-1:0]         nd;
  logic [5:0]            stack [VALUE_BITS];

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  logic [5:0]            rad_in;
  logic [DW-1:0]         dividend_next;
  logic [5:0]            rem_next;
  logic                  step_last;
  logic [NW-1:0]         nd_dec;

  // Input conditioning: magnitude and saturated base
  assign raw    = value[VALUE_BITS-1:0];
  assign mag_in = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign rad_in = (radix <= 6'd1) ? ria_pkg::DEFAULT_RADIX :
                  (radix > ria_pkg::MAX_RADIX) ? ria_pkg::MAX_RADIX : radix;

  // One chunk of restoring division; quotient bits shift in at the bottom
  always_comb begin
    logic [6:0]    r;
    logic [DW-1:0] d;
    r = {1'b0, rem};
    d = dividend;
    for (int i = 0; i < ria_pkg::CHUNK_BITS; i++) begin
      r = {r[5:0], d[DW-1]};
      d = {d[DW-2:0], 1'b0};
      if (r >= {1'b0, rad}) begin
        r    = r - {1'b0, rad};
        d[0] = 1'b1;
      end
    end
    rem_next      = r[5:0];
    dividend_next = d;
  end

  assign step_last = (step == SW'(STEPS - 1));
  assign nd_dec    = nd - 1'b1;

  // Status to controller
  always_comb begin
    status.step_last = step_last;
    status.quot_zero = (dividend_next == '0);
    status.neg       = neg;
    status.nd_one    = (nd == NW'(1));
  end

  // Control counters and output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      nd     <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit;
      if (cmd.load) begin
        step <= '0;
        nd   <= '0;
      end else if (cmd.div_step) begin
        if (step_last) begin
          step <= '0;
          nd   <= nd + 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end else if (cmd.emit_digit) begin
        nd <= nd_dec;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend <= DW'(mag_in);
      rad      <= rad_in;
      neg      <= raw[VALUE_BITS-1];
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend_next;
      rem      <= step_last ? 6'd0 : rem_next;
      if (step_last) stack[nd[IW-1:0]] <= rem_next;
    end
    if (cmd.emit_sign) begin
      char_code <= ria_pkg::CH_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= ria_pkg::digit_code(stack[nd_dec[IW-1:0]]);
      last      <= (nd == NW'(1));
    end
  end

endmodule
